/* rtl/morse_code_keyer_top_macros.svh */
// assertion macros for the morse code keyer
`ifndef MORSE_CODE_KEYER_TOP_MACROS_SVH
`define MORSE_CODE_KEYER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MCK_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mck assertion failed");

// next-cycle implication, disabled during reset
`define MCK_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mck assertion failed");

`endif

/* rtl/mck_pkg.sv */
// package: constants, pattern tables, types and decode function for the morse keyer
`default_nettype none
package mck_pkg;

    localparam int UNIT_W       = 14;
    localparam int DUR_W        = 16;
    localparam int CHAR_W       = 8;
    localparam int MAX_ELEMS    = 5;
    localparam int LEN_W        = 3;
    localparam int NUM_LETTERS  = 26;
    localparam int NUM_SYMBOLS  = 36;
    localparam int SEL_W        = 6;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 14'd45;

    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    // element count per symbol, A-Z then 0-9
    localparam logic [LEN_W-1:0] PAT_LEN [NUM_SYMBOLS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // element bits, first element in the highest used bit, 1 = dah
    localparam logic [MAX_ELEMS-1:0] PAT_BITS [NUM_SYMBOLS] = '{
        5'd1,  5'd8,  5'd10, 5'd4,  5'd0,  5'd2,  5'd6,  5'd0,  5'd0,  5'd7,
        5'd5,  5'd4,  5'd3,  5'd2,  5'd7,  5'd6,  5'd13, 5'd2,  5'd0,  5'd1,
        5'd1,  5'd1,  5'd3,  5'd9,  5'd11, 5'd12,
        5'd31, 5'd15, 5'd7,  5'd3,  5'd1,  5'd0,  5'd16, 5'd24, 5'd28, 5'd30
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TONE,
        ST_GAP,
        ST_CLOSE,
        ST_WORD
    } seg_state_t;

    typedef struct packed {
        logic                 known;
        logic [LEN_W-1:0]     len;
        logic [MAX_ELEMS-1:0] pat;   // first element in the top bit
    } dec_t;

    typedef struct packed {
        logic              key_down;
        logic [DUR_W-1:0]  duration_ms;
        logic              last_of_char;
    } seg_t;

    // character hand-off from the queue to the segment generator
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
    } chr_t;

    function automatic dec_t mck_decode(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        logic [SEL_W-1:0]  sel;
        dec_t              d;
        c   = code;
        sel = '0;
        d   = '0;
        if (c inside {[CH_LA:CH_LZ]})
            c = c - CASE_OFS;
        if (c inside {[CH_UA:CH_UZ]})
        begin
            d.known = 1'b1;
            sel     = SEL_W'(c - CH_UA);
        end
        else if (c inside {[CH_0:CH_9]})
        begin
            d.known = 1'b1;
            sel     = SEL_W'(c - CH_0) + SEL_W'(NUM_LETTERS);
        end
        if (d.known)
        begin
            d.len = PAT_LEN[sel];
            d.pat = MAX_ELEMS'(PAT_BITS[sel] << (LEN_W'(MAX_ELEMS) - d.len));
        end
        return d;
    endfunction

endpackage
`default_nettype wire

/* rtl/morse_code_keyer_top.sv */
// top level of the morse code keyer: config register, character queue, segment generator
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   char_code
//  out      output     out_valid/out_stall key_down, duration_ms, last_of_char
//  cfg      input      cfg_we              cfg_wdata (unit length, ms)
//
// one segment per cycle from the generator unless out_stall holds it: a letter or digit
// takes 2 to 10 segments, any other character 1 segment; the next character is read out
// of the queue ram only after the previous take, so short characters can leave the output idle.
// characters are taken every cycle until the ram holds QUEUE_DEPTH, plus one held.
// asynchronous active-low reset; the queue ram holds no reset values.
// a stalled segment holds in the output register while the generator waits.
`default_nettype none
module morse_code_keyer_top #(
    parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [mck_pkg::UNIT_W-1:0] cfg_wdata,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [mck_pkg::CHAR_W-1:0] char_code,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            key_down,
    output logic [mck_pkg::DUR_W-1:0]       duration_ms,
    output logic                            last_of_char
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] unit_reg;
    chr_t              chr;
    logic              chr_take;
    seg_t              seg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_reg <= UNIT_RESET;
        else if (cfg_we)
            unit_reg <= cfg_wdata;
    end

    mck_char_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .chr       (chr),
        .chr_take  (chr_take)
    );

    mck_seg_gen u_seg_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .chr       (chr),
        .chr_take  (chr_take),
        .unit      (unit_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .seg_out   (seg)
    );

    assign key_down     = seg.key_down;
    assign duration_ms  = seg.duration_ms;
    assign last_of_char = seg.last_of_char;

endmodule
`default_nettype wire

/* rtl/mck_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module mck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/mck_char_queue.sv */
// character queue: ring buffer in ram, read pointer logic and a hold register
`default_nettype none
module mck_char_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [mck_pkg::CHAR_W-1:0] char_code,
    output mck_pkg::chr_t                  chr,
    input  wire logic                      chr_take
);
    import mck_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = AW + 1;

    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rd_pend_reg;
    logic              hold_valid_reg, hold_valid_next;
    logic [CHAR_W-1:0] hold_char_reg;
    logic [CHAR_W-1:0] ram_rdata;
    logic              wr_en;
    logic              rd_issue;

    assign in_stall = (count_reg == CNT_W'(DEPTH));
    assign wr_en    = in_valid && !in_stall;
    // one read in flight, and only into an empty hold register
    assign rd_issue = (count_reg != '0) && !rd_pend_reg && !hold_valid_reg;

    mck_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (char_code),
        .re    (rd_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_issue)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_issue)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_issue)
            count_next = count_reg - 1'b1;
        hold_valid_next = hold_valid_reg;
        if (rd_pend_reg)
            hold_valid_next = 1'b1;
        else if (chr_take)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            rd_pend_reg    <= rd_issue;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
            hold_char_reg <= ram_rdata;
    end

    assign chr.valid = hold_valid_reg;
    assign chr.code  = hold_char_reg;

endmodule
`default_nettype wire

/* rtl/mck_seg_gen.sv */
// segment generator: expands one character into keying segments, output register
`default_nettype none
module mck_seg_gen (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mck_pkg::chr_t              chr,
    output logic                            chr_take,
    input  wire logic [mck_pkg::UNIT_W-1:0] unit,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output mck_pkg::seg_t                   seg_out
);
    import mck_pkg::*;

    seg_state_t           state_reg, state_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [MAX_ELEMS-1:0] pat_reg, pat_next;
    logic                 out_valid_reg;
    seg_t                 seg_reg;
    seg_t                 seg;
    dec_t                 dec;
    logic                 out_free;
    logic                 emit;
    logic                 done;
    logic [DUR_W-1:0]     dur1, dur3, dur4;

    assign dec      = mck_decode(chr.code);
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (state_reg != ST_IDLE) && out_free;
    assign done     = (state_reg == ST_IDLE) || (emit && seg.last_of_char);
    assign chr_take = chr.valid && done;

    assign dur1 = DUR_W'(unit);
    assign dur3 = dur1 + (dur1 << 1);
    assign dur4 = dur1 << 2;

    // next state
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        pat_next   = pat_reg;
        case (state_reg)
            ST_IDLE:
                state_next = ST_IDLE;
            ST_TONE:
                if (emit)
                    state_next = (rem_reg > LEN_W'(1)) ? ST_GAP : ST_CLOSE;
            ST_GAP:
                if (emit)
                begin
                    state_next = ST_TONE;
                    rem_next   = rem_reg - 1'b1;
                    pat_next   = pat_reg << 1;
                end
            ST_CLOSE, ST_WORD:
                if (emit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (chr_take)
        begin
            state_next = dec.known ? ST_TONE : ST_WORD;
            rem_next   = dec.len;
            pat_next   = dec.pat;
        end
    end

    // segment for the current state
    always_comb
    begin
        seg = '0;
        case (state_reg)
            ST_TONE:
            begin
                seg.key_down    = 1'b1;
                seg.duration_ms = pat_reg[MAX_ELEMS-1] ? dur3 : dur1;
            end
            ST_GAP:
                seg.duration_ms = dur1;
            ST_CLOSE:
            begin
                seg.duration_ms  = dur3;
                seg.last_of_char = 1'b1;
            end
            ST_WORD:
            begin
                seg.duration_ms  = dur4;
                seg.last_of_char = 1'b1;
            end
            default:
                seg = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            pat_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            pat_reg   <= pat_next;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            seg_reg <= seg;
    end

    assign out_valid = out_valid_reg;
    assign seg_out   = seg_reg;

endmodule
`default_nettype wire

/* rtl/mck_checker.sv */
// port-level checker for the morse code keyer, bound to the top level
`default_nettype none
`include "morse_code_keyer_top_macros.svh"
module mck_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic                      key_down,
    input  wire logic [mck_pkg::DUR_W-1:0] duration_ms,
    input  wire logic                      last_of_char
);
    import mck_pkg::*;

    // a stalled transaction stays offered
    `MCK_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(duration_ms))
    // a tone never closes a character
    `MCK_ASSERT_IMP(a_tone_not_last, clk, rst_n, out_valid && key_down, !last_of_char)
    // every tone transaction is followed at once by a silent segment
    `MCK_ASSERT_NXT(a_tone_then_gap, clk, rst_n, out_valid && !out_stall && key_down, out_valid && !key_down)
    // an inner gap is followed at once by the next tone
    `MCK_ASSERT_NXT(a_gap_then_tone, clk, rst_n, out_valid && !out_stall && !key_down && !last_of_char, out_valid && key_down)

endmodule

bind morse_code_keyer_top mck_checker u_mck_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_down     (key_down),
    .duration_ms  (duration_ms),
    .last_of_char (last_of_char)
);
`default_nettype wire

/* tb/tb_morse_code_keyer_top.sv */
// testbench for the morse code keyer: directed and random characters against a segment predictor
`timescale 1ns / 1ps
module tb_morse_code_keyer_top;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RAND_PHASES = 4;
    localparam int RAND_PER_PHASE = 100;

    typedef struct packed {
        logic        key_down;
        logic [15:0] duration_ms;
        logic        last_of_char;
    } seg_exp_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [mck_pkg::UNIT_W-1:0] cfg_wdata;
    logic                       in_valid;
    logic                       in_stall;
    logic [mck_pkg::CHAR_W-1:0] char_code;
    logic                       out_valid;
    logic                       out_stall;
    logic                       key_down;
    logic [mck_pkg::DUR_W-1:0]  duration_ms;
    logic                       last_of_char;

    seg_exp_t                   pending_segs[$];
    logic [13:0]                unit_ms = 14'd45;
    int                         err_count = 0;
    int                         idle_cycles = 0;
    int                         hold_off_len = 0;
    bit                         tx_idle_on = 1'b0;
    bit                         rx_idle_on = 1'b0;

    morse_code_keyer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_down    (key_down),
        .duration_ms (duration_ms),
        .last_of_char(last_of_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // dots and dashes for A-Z then 0-9
    function automatic string morse_pattern(input int sel);
        case (sel)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            25: return "--..";
            26: return "-----";
            27: return ".----";
            28: return "..---";
            29: return "...--";
            30: return "....-";
            31: return ".....";
            32: return "-....";
            33: return "--...";
            34: return "---..";
            35: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic void predict_segments(input logic [7:0] code);
        logic [7:0]  c;
        int          sel;
        string       pat;
        logic [15:0] u1;
        logic [15:0] u3;
        logic [15:0] u4;
        c   = code;
        sel = -1;
        u1  = 16'(unit_ms);
        u3  = 16'(unit_ms * 3);
        u4  = 16'(unit_ms * 4);
        if (c >= "a" && c <= "z")
            c = c - ("a" - "A");
        if (c >= "A" && c <= "Z")
            sel = int'(c - "A");
        else if (c >= "0" && c <= "9")
            sel = 26 + int'(c - "0");
        if (sel < 0)
        begin
            // anything else is the tail of a word gap
            pending_segs.push_back('{1'b0, u4, 1'b1});
            return;
        end
        pat = morse_pattern(sel);
        for (int i = 0; i < pat.len(); i++)
        begin
            pending_segs.push_back('{1'b1, (pat[i] == "-") ? u3 : u1, 1'b0});
            if (i + 1 < pat.len())
                pending_segs.push_back('{1'b0, u1, 1'b0});
        end
        pending_segs.push_back('{1'b0, u3, 1'b1});
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 50)
            $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic send_char(input logic [7:0] code);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        do
            @(posedge clk);
        while (in_stall);
        predict_segments(code);
    endtask

    task automatic drain_segments();
        in_valid <= 1'b0;
        while (pending_segs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_unit(input logic [13:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        unit_ms   = value;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'("A" + $urandom_range(0, 25));
        else if (r < 60)
            return 8'("a" + $urandom_range(0, 25));
        else if (r < 80)
            return 8'("0" + $urandom_range(0, 9));
        else if (r < 90)
            return " ";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [13:0] pick_unit();
        if ($urandom_range(0, 3) == 0)
            return 14'($urandom_range(1, 16));
        return 14'($urandom_range(1, 16383));
    endfunction

    // receiver pacing: long hold-off on request, else random stall bursts while rx_idle_on is set
    initial
    begin : rx_pacer
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                n            = hold_off_len;
                hold_off_len = 0;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : seg_checker
        seg_exp_t exp_seg;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_segs.size() == 0)
                report_mismatch("segment with none pending, duration_ms", duration_ms, -1);
            else
            begin
                exp_seg = pending_segs.pop_front();
                if (key_down !== exp_seg.key_down)
                    report_mismatch("key_down", key_down, exp_seg.key_down);
                if (duration_ms !== exp_seg.duration_ms)
                    report_mismatch("duration_ms", duration_ms, exp_seg.duration_ms);
                if (last_of_char !== exp_seg.last_of_char)
                    report_mismatch("last_of_char", last_of_char, exp_seg.last_of_char);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed_chars();
        logic [7:0] codes[$];
        codes = '{"A", "Z", "a", "z", "0", "9", " ", 8'h00, 8'hFF, 8'h80,
                  "@", "[", 8'h60, "{", "/", ":"};
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (codes[i])
            send_char(codes[i]);
        drain_segments();
    endtask

    task automatic test_unit_extremes();
        write_unit(14'd16383);
        send_char("0");
        send_char(" ");
        drain_segments();
        write_unit(14'd1);
        send_char("E");
        send_char(" ");
        drain_segments();
        // zero unit length is taken as written
        write_unit(14'd0);
        send_char("H");
        send_char(".");
        drain_segments();
    endtask

    task automatic test_random_text();
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_unit(pick_unit());
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 1);
            repeat (RAND_PER_PHASE)
                send_char(pick_char());
            drain_segments();
        end
    endtask

    task automatic test_output_holdoff();
        write_unit(pick_unit());
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        repeat (30)
            send_char(pick_char());
        drain_segments();
    endtask

    task automatic test_quiet_tail();
        write_unit(pick_unit());
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (30)
            send_char(pick_char());
        drain_segments();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        char_code <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_chars();
        test_unit_extremes();
        test_random_text();
        test_output_holdoff();
        test_quiet_tail();

        repeat (16) @(posedge clk);
        foreach (pending_segs[i])
            report_mismatch("segment never produced, duration_ms", -1,
                            pending_segs[i].duration_ms);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
